@@ rtl/core/bchd_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and word types of the cascaded boxcar haar detail core
package bchd_pkg;

    localparam int SHORT_WIN   = 5;
    localparam int LONG_WIN    = 256;
    localparam int SAMPLE_BITS = 24;

    localparam int SHORT_SUM_BITS = SAMPLE_BITS + $clog2(SHORT_WIN);
    localparam int LONG_SUM_BITS  = SHORT_SUM_BITS + $clog2(LONG_WIN);
    localparam int SHORT_CNT_BITS = $clog2(SHORT_WIN + 1);
    localparam int LONG_POS_BITS  = $clog2(LONG_WIN);
    localparam int LONG_FILL_BITS = $clog2(LONG_WIN + 1);

    localparam int DETAIL_BITS = 36;
    localparam int INDEX_BITS  = 15;
    localparam int HAAR_Q15    = 23170;
    localparam int HAAR_SHIFT  = 15;
    localparam int COEF_BITS   = 16;
    localparam int DIFF_BITS   = LONG_SUM_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + COEF_BITS;
    localparam int OCC_BITS    = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [DETAIL_BITS-1:0] detail;
        logic [INDEX_BITS-1:0]         detail_index;
    } t_out_word;

    typedef struct packed {
        logic signed [LONG_SUM_BITS-1:0] even;
        logic signed [LONG_SUM_BITS-1:0] odd;
        logic [INDEX_BITS-1:0]           index;
    } t_pair;

endpackage

@@ rtl/core/boxcar_cascade_haar_detail_core.sv @@
`timescale 1ns / 1ps
// top level: cascaded boxcar sums feeding a haar detail stage
//
// input channel: i_in_valid / o_in_ready carry one sample word (signed sample
// and frame_start flag). frame_start clears both windows, the pairing and the
// detail index before its sample is taken in.
// output channel: o_out_valid / i_out_ready carry one detail word (signed
// detail and its index within the record).
// the short window is a chain of tap cells shifting once per accepted word; the
// long window is a 256-entry ram with a registered read feeding the running sum.
// throughput: one input word per cycle while o_in_ready is high. a detail
// appears once per two inputs after the windows have filled (5 + 256 + 1
// words into a record). the input word that completes a pair is registered
// for the long stage; then the sum update, the subtract and multiply, and the
// output each add a register. when the receiver stalls, up to three detail
// words queue in the multiply stages and output register; o_in_ready drops
// only when those slots and the word in flight could fill them.
// reset clears all sums, counters and the short chain and behaves like a
// record start; the long window ram needs no clearing since its entries are
// read only after being written in the current record.
module boxcar_cascade_haar_detail_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bchd_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bchd_pkg::t_out_word  o_out_word
);
    import bchd_pkg::*;

    localparam int SLOTS = 3;

    // short stage
    logic signed [SAMPLE_BITS-1:0]    w_tap [SHORT_WIN];
    logic signed [SHORT_SUM_BITS-1:0] r_short_sum, n_short_sum;
    logic [SHORT_CNT_BITS-1:0]        r_short_cnt, n_short_cnt;
    logic [LONG_POS_BITS-1:0]         r_long_pos, n_long_pos;
    logic [LONG_FILL_BITS-1:0]        r_long_fill, n_long_fill;

    // word handed to the long stage
    logic                             r_b_s1vld, n_b_s1vld;
    logic                             r_b_clr, n_b_clr;
    logic                             r_b_full, n_b_full;
    logic signed [SHORT_SUM_BITS-1:0] r_b_s1, n_b_s1;
    logic [LONG_POS_BITS-1:0]         r_b_addr, n_b_addr;

    // long stage and pairing
    logic signed [LONG_SUM_BITS-1:0]  r_long_sum, n_long_sum;
    logic signed [LONG_SUM_BITS-1:0]  r_even, n_even;
    logic                             r_phase, n_phase;
    logic [INDEX_BITS-1:0]            r_index, n_index;

    logic                             w_in_acc;
    logic                             w_clr;
    logic signed [SHORT_SUM_BITS-1:0] w_short_base;
    logic [SHORT_CNT_BITS-1:0]        w_cnt_base;
    logic [LONG_POS_BITS-1:0]         w_pos_base;
    logic [LONG_FILL_BITS-1:0]        w_fill_base;
    logic                             w_s1_evt;
    logic signed [SHORT_SUM_BITS-1:0] w_s1;
    logic [SHORT_SUM_BITS-1:0]        w_rd_data;
    logic signed [SHORT_SUM_BITS-1:0] w_old;
    logic signed [LONG_SUM_BITS-1:0]  w_s2;
    logic                             w_emit;
    t_pair                            w_pair;
    logic [OCC_BITS-1:0]              w_occ;
    logic [OCC_BITS:0]                w_pending;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_clr    = i_in_word.frame_start;

    for (genvar g = 0; g < SHORT_WIN; g++) begin : g_tap
        if (g == 0) begin : g_head
            bchd_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_in_acc),
                .i_clr   (1'b0),
                .i_d     (i_in_word.sample),
                .o_q     (w_tap[g])
            );
        end else begin : g_body
            bchd_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_in_acc),
                .i_clr   (w_clr),
                .i_d     (w_tap[g-1]),
                .o_q     (w_tap[g])
            );
        end
    end

    // short sum and long window addressing
    always_comb begin
        w_short_base = w_clr ? '0 : r_short_sum;
        w_cnt_base   = w_clr ? '0 : r_short_cnt;
        w_pos_base   = w_clr ? '0 : r_long_pos;
        w_fill_base  = w_clr ? '0 : r_long_fill;
        w_s1 = w_short_base + SHORT_SUM_BITS'(i_in_word.sample)
             - (w_clr ? SHORT_SUM_BITS'(0) : SHORT_SUM_BITS'(w_tap[SHORT_WIN-1]));
        w_s1_evt = w_in_acc && (w_cnt_base == SHORT_CNT_BITS'(SHORT_WIN));

        n_short_sum = r_short_sum;
        n_short_cnt = r_short_cnt;
        n_long_pos  = r_long_pos;
        n_long_fill = r_long_fill;
        if (w_in_acc) begin
            n_short_sum = w_s1;
            n_short_cnt = (w_cnt_base == SHORT_CNT_BITS'(SHORT_WIN))
                        ? w_cnt_base : w_cnt_base + 1'b1;
            n_long_pos  = w_pos_base;
            n_long_fill = w_fill_base;
            if (w_s1_evt) begin
                n_long_pos  = (w_pos_base == LONG_POS_BITS'(LONG_WIN - 1))
                            ? '0 : w_pos_base + 1'b1;
                n_long_fill = (w_fill_base == LONG_FILL_BITS'(LONG_WIN))
                            ? w_fill_base : w_fill_base + 1'b1;
            end
        end

        n_b_s1vld = w_s1_evt;
        n_b_clr   = w_in_acc && w_clr;
        n_b_full  = (w_fill_base == LONG_FILL_BITS'(LONG_WIN));
        n_b_s1    = w_s1;
        n_b_addr  = w_pos_base;
    end

    bchd_ram #(
        .WIDTH (SHORT_SUM_BITS),
        .DEPTH (LONG_WIN)
    ) u_long_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_s1vld),
        .i_wr_addr (r_b_addr),
        .i_wr_data (r_b_s1),
        .i_rd_en   (w_s1_evt),
        .i_rd_addr (w_pos_base),
        .o_rd_data (w_rd_data)
    );

    // long sum update and even/odd pairing
    always_comb begin
        w_old  = r_b_full ? $signed(w_rd_data) : SHORT_SUM_BITS'(0);
        w_s2   = r_long_sum + LONG_SUM_BITS'(r_b_s1) - LONG_SUM_BITS'(w_old);
        w_emit = r_b_s1vld && r_b_full && r_phase;

        n_long_sum = r_long_sum;
        n_even     = r_even;
        n_phase    = r_phase;
        n_index    = r_index;
        if (r_b_clr) begin
            n_long_sum = '0;
            n_even     = '0;
            n_phase    = 1'b0;
            n_index    = '0;
        end else if (r_b_s1vld) begin
            n_long_sum = w_s2;
            if (r_b_full) begin
                n_phase = !r_phase;
                if (!r_phase) begin
                    n_even = w_s2;
                end else begin
                    n_index = r_index + 1'b1;
                end
            end
        end

        w_pair.even  = r_even;
        w_pair.odd   = w_s2;
        w_pair.index = r_index;
    end

    bchd_haar u_haar (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair_vld  (w_emit),
        .i_pair      (w_pair),
        .o_occupancy (w_occ),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // words that may still need a slot: the one in flight plus those queued
    assign w_pending  = (OCC_BITS + 1)'(w_emit) + (OCC_BITS + 1)'(w_occ);
    assign o_in_ready = (w_pending < (OCC_BITS + 1)'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_sum <= '0;
            r_short_cnt <= '0;
            r_long_pos  <= '0;
            r_long_fill <= '0;
            r_b_s1vld   <= 1'b0;
            r_b_clr     <= 1'b0;
            r_b_full    <= 1'b0;
            r_long_sum  <= '0;
            r_even      <= '0;
            r_phase     <= 1'b0;
            r_index     <= '0;
        end else begin
            r_short_sum <= n_short_sum;
            r_short_cnt <= n_short_cnt;
            r_long_pos  <= n_long_pos;
            r_long_fill <= n_long_fill;
            r_b_s1vld   <= n_b_s1vld;
            r_b_clr     <= n_b_clr;
            r_b_full    <= n_b_full;
            r_long_sum  <= n_long_sum;
            r_even      <= n_even;
            r_phase     <= n_phase;
            r_index     <= n_index;
        end
        r_b_s1   <= n_b_s1;
        r_b_addr <= n_b_addr;
    end

endmodule

@@ rtl/core/bchd_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
module bchd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/bchd_tap_cell.sv @@
`timescale 1ns / 1ps
// one cell of the short window delay chain
module bchd_tap_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_clr,
    input  logic signed [bchd_pkg::SAMPLE_BITS-1:0] i_d,
    output logic signed [bchd_pkg::SAMPLE_BITS-1:0] o_q
);
    import bchd_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_q;
    logic signed [SAMPLE_BITS-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_en) begin
            n_q = i_clr ? '0 : i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/core/bchd_haar.sv @@
`timescale 1ns / 1ps
// haar detail multiply stages and output register with stall handling
module bchd_haar (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pair_vld,
    input  bchd_pkg::t_pair               i_pair,
    output logic [bchd_pkg::OCC_BITS-1:0] o_occupancy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bchd_pkg::t_out_word           o_out_word
);
    import bchd_pkg::*;

    localparam logic signed [COEF_BITS-1:0] HAAR_COEF = COEF_BITS'(HAAR_Q15);

    logic                          r_c_vld;
    t_pair                         r_c_pair;
    logic                          r_d_vld;
    logic signed [PROD_BITS-1:0]   r_d_prod;
    logic [INDEX_BITS-1:0]         r_d_index;
    logic                          r_o_vld;
    t_out_word                     r_o_word;

    logic                          w_out_adv;
    logic                          w_d_adv;
    logic                          w_c_adv;
    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [PROD_BITS-1:0]   w_prod;

    // a stage moves on when the next one is empty or moving too
    assign w_out_adv = !r_o_vld || i_out_ready;
    assign w_d_adv   = !r_d_vld || w_out_adv;
    assign w_c_adv   = !r_c_vld || w_d_adv;

    assign w_diff = DIFF_BITS'(r_c_pair.even) - DIFF_BITS'(r_c_pair.odd);
    assign w_prod = PROD_BITS'(w_diff) * PROD_BITS'(HAAR_COEF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_c_adv) begin
                r_c_vld <= i_pair_vld;
            end
            if (w_d_adv) begin
                r_d_vld <= r_c_vld;
            end
            if (w_out_adv) begin
                r_o_vld <= r_d_vld;
            end
        end
        if (w_c_adv) begin
            r_c_pair <= i_pair;
        end
        if (w_d_adv) begin
            r_d_prod  <= w_prod;
            r_d_index <= r_c_pair.index;
        end
        if (w_out_adv) begin
            // arithmetic shift right, low bits kept
            r_o_word.detail       <= r_d_prod[HAAR_SHIFT +: DETAIL_BITS];
            r_o_word.detail_index <= r_d_index;
        end
    end

    assign o_occupancy = OCC_BITS'({1'b0, r_c_vld}) + OCC_BITS'({1'b0, r_d_vld})
                       + OCC_BITS'({1'b0, r_o_vld});
    assign o_out_valid = r_o_vld;
    assign o_out_word  = r_o_word;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for the boxcar cascade haar detail core: directed runs, random records
module tb_top;
    import bchd_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_NEG1 = {SAMPLE_BITS{1'b1}};
    localparam int unsigned REC_COUNT_MAX = 65535;
    localparam int          HOLD_CYCLES   = 1500;
    localparam int          RAND_WORDS    = 330;
    localparam int          RAND_DETAILS  = 20;
    localparam int          N_RUNS        = 6;

    typedef enum logic [1:0] {FILL_CONST, FILL_ALT, FILL_RAND} t_fill;
    typedef enum logic [1:0] {MIX_FULL, MIX_SMALL, MIX_EDGES} t_mix;

    // one directed run: count samples, frame_start on the first if start is set
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          start;
        logic [16:0]                   count;
        t_fill                         fill;
        logic                          zero_detail;
    } t_run;

    t_run dir_runs [N_RUNS] = '{
        // no record start after reset, 5 long sums so the last even is dropped
        '{24'sh3A5C71, 1'b0, 17'd266,   FILL_CONST, 1'b1},
        // windows primed at full scale, then a step to the other extreme
        '{S_MAX,       1'b1, 17'd261,   FILL_CONST, 1'b0},
        '{S_MIN,       1'b0, 17'd40,    FILL_CONST, 1'b0},
        '{24'sh000000, 1'b1, 17'd5,     FILL_CONST, 1'b0},
        '{24'sh00FF00, 1'b1, 17'd1,     FILL_CONST, 1'b0},
        '{24'sh000000, 1'b1, 17'd6,     FILL_RAND,  1'b0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    // predictor state
    longint                short_taps [SHORT_WIN];
    longint                short_total;
    int unsigned           short_ptr;
    int unsigned           samples_in_rec;
    longint                long_taps [LONG_WIN];
    longint                long_total;
    int unsigned           long_ptr;
    int unsigned           long_seen;
    longint                even_hold;
    bit                    odd_next;
    logic [INDEX_BITS-1:0] next_index;

    t_out_word   detail_q [$];
    int          err_count = 0;
    int unsigned words_sent = 0;
    int unsigned records = 0;
    int unsigned details_due = 0;
    int unsigned details_seen = 0;
    int unsigned index_wraps = 0;
    int unsigned in_stalls = 0;
    logic [INDEX_BITS-1:0] last_index = '0;

    bit          hold_req = 1'b0;
    bit          hold_on = 1'b0;
    bit          rdy_calm = 1'b0;
    int unsigned rdy_wait = 0;
    int unsigned rdy_phase = 300;

    boxcar_cascade_haar_detail_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_record_state();
        foreach (short_taps[i]) short_taps[i] = 0;
        foreach (long_taps[i]) long_taps[i] = 0;
        short_total    = 0;
        short_ptr      = 0;
        samples_in_rec = 0;
        long_total     = 0;
        long_ptr       = 0;
        long_seen      = 0;
        even_hold      = 0;
        odd_next       = 1'b0;
        next_index     = '0;
    endfunction

    // advances the cascade by one sample, returns 1 when a detail pops out
    function automatic bit predict_detail(input t_in_word w, output t_out_word r);
        longint x;
        longint prod;
        bit     primed;
        r = '0;
        x = w.sample;
        if (w.frame_start)
            clear_record_state();

        primed = samples_in_rec >= SHORT_WIN;
        short_total += primed ? x - short_taps[short_ptr] : x;
        short_taps[short_ptr] = x;
        short_ptr = (short_ptr + 1 >= SHORT_WIN) ? 0 : short_ptr + 1;
        if (samples_in_rec < REC_COUNT_MAX)
            samples_in_rec++;
        if (!primed)
            return 1'b0;

        primed = long_seen >= LONG_WIN;
        long_total += primed ? short_total - long_taps[long_ptr] : short_total;
        long_taps[long_ptr] = short_total;
        long_ptr = (long_ptr + 1 >= LONG_WIN) ? 0 : long_ptr + 1;
        if (long_seen < LONG_WIN)
            long_seen++;
        if (!primed)
            return 1'b0;

        if (!odd_next) begin
            even_hold = long_total;
            odd_next  = 1'b1;
            return 1'b0;
        end
        odd_next = 1'b0;
        prod = (even_hold - long_total) * longint'(HAAR_Q15);
        r.detail       = DETAIL_BITS'(prod >>> HAAR_SHIFT);
        r.detail_index = next_index;
        next_index     = next_index + 1'b1;
        return 1'b1;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample(input t_mix mix);
        int s;
        case (mix)
            MIX_SMALL: begin
                s = int'($urandom_range(0, 511)) - 256;
                return SAMPLE_BITS'(s);
            end
            MIX_EDGES: begin
                case ($urandom_range(0, 3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return S_NEG1;
                    default: return '0;
                endcase
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input t_in_word w, input bit no_gaps, input bit zero_known);
        int unsigned idle;
        t_out_word   r;
        idle = no_gaps ? 0 : idle_len();
        repeat (idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            in_stalls++;
            @(posedge i_clk);
        end
        words_sent++;
        if (w.frame_start)
            records++;
        if (predict_detail(w, r)) begin
            // constant records settle to a zero detail
            if (zero_known)
                r.detail = '0;
            detail_q.push_back(r);
            details_due++;
        end
    endtask

    // receiver: random ready, calm stretches, and one long hold-off
    always @(posedge i_clk) begin
        if (rdy_phase == 0) begin
            rdy_calm  <= ($urandom_range(0, 2) == 0);
            rdy_phase <= $urandom_range(200, 800);
        end else begin
            rdy_phase <= rdy_phase - 1;
        end
        if (!i_rst_n || hold_on) begin
            i_out_ready <= 1'b0;
        end else if (rdy_wait != 0) begin
            i_out_ready <= 1'b0;
            rdy_wait    <= rdy_wait - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!rdy_calm && $urandom_range(0, 3) == 0)
                rdy_wait <= idle_len();
        end
    end

    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            details_seen++;
            if (o_out_word.detail_index == '0 && last_index == '1)
                index_wraps++;
            last_index <= o_out_word.detail_index;
            if (detail_q.size() == 0) begin
                $display("%0t: unexpected detail word, detail %0d index %0d", $time,
                         o_out_word.detail, o_out_word.detail_index);
                err_count++;
            end else begin
                exp_word = detail_q.pop_front();
                if (o_out_word.detail !== exp_word.detail) begin
                    $display("%0t: detail mismatch, expected %0d, got %0d", $time,
                             exp_word.detail, o_out_word.detail);
                    err_count++;
                end
                if (o_out_word.detail_index !== exp_word.detail_index) begin
                    $display("%0t: detail_index mismatch, expected %0d, got %0d", $time,
                             exp_word.detail_index, o_out_word.detail_index);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(100_000_000);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        t_in_word    w;
        t_run        run;
        t_mix        mix;
        int unsigned rec_len;
        int unsigned rand_words;
        int unsigned rand_details;
        int unsigned pick;
        bit          calm;
        bit          first_rec;

        clear_record_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_RUNS; k++) begin
            run = dir_runs[k];
            for (int n = 0; n < int'(run.count); n++) begin
                case (run.fill)
                    FILL_ALT:  w.sample = n[0] ? ~run.value : run.value;
                    FILL_RAND: w.sample = random_sample(MIX_FULL);
                    default:   w.sample = run.value;
                endcase
                w.frame_start = run.start && (n == 0);
                send_sample(w, 1'b0, run.zero_detail);
            end
        end

        // random records: the first long enough to emit details, later ones mostly short
        hold_req     <= 1'b1;
        rand_words   = 0;
        rand_details = details_due;
        first_rec    = 1'b1;
        while (rand_words < RAND_WORDS || details_due - rand_details < RAND_DETAILS) begin
            pick = $urandom_range(0, 99);
            if (first_rec)
                rec_len = 310;
            else if (pick < 75)
                rec_len = $urandom_range(1, 60);
            else if (pick < 90)
                rec_len = $urandom_range(61, 150);
            else
                rec_len = $urandom_range(262, 300);
            mix  = t_mix'($urandom_range(0, 2));
            calm = first_rec || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < int'(rec_len); n++) begin
                w.sample      = random_sample(mix);
                w.frame_start = (n == 0) && (first_rec || $urandom_range(0, 9) != 0);
                send_sample(w, calm, 1'b0);
                rand_words++;
            end
            first_rec = 1'b0;
        end
        i_in_valid <= 1'b0;

        while (detail_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("run covered %0d samples in %0d records, %0d random, %0d input stall cycles",
                 words_sent, records, rand_words, in_stalls);
        $display("%0d detail words checked of %0d predicted, index wrapped %0d times",
                 details_seen, details_due, index_wraps);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bchd_pkg.sv
rtl/core/bchd_ram.sv
rtl/core/bchd_tap_cell.sv
rtl/core/bchd_haar.sv
rtl/core/boxcar_cascade_haar_detail_core.sv
sim/tb_top.sv
